[design/wme_pkg.sv]
// Shared types and constants for the windowed mean with extremes block.
package wme_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FILLED_W   = 7;
   localparam int QUOT_W     = 16;
   localparam int STEP_W     = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   typedef struct packed {
      logic take;     // latch sample, read oldest entry
      logic update;   // write store, update sum, count, extremes
      logic load;     // load divider
      logic step;     // one quotient bit
      logic finish;   // load result register
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

[design/wme_ctrl.sv]
// Controller state machine for the windowed mean with extremes block.
module wme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  wme_pkg::status_type status,
   output wme_pkg::cmd_type    cmd
);

   wme_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wme_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         wme_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = wme_pkg::ST_UPDATE;
            end
         end
         wme_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = wme_pkg::ST_LOAD;
         end
         wme_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = wme_pkg::ST_DIV;
         end
         wme_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = wme_pkg::ST_DONE;
            end
         end
         wme_pkg::ST_DONE: begin
            // wait for the result register to drain
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = wme_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wme_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/wme_dpath.sv]
// Datapath: ring store, running sum, extremes, serial divider, result register.
module wme_dpath #(
   parameter int WINDOW = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wme_pkg::cmd_type                   cmd,
   output wme_pkg::status_type                status,
   input  logic [wme_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [wme_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int SUM_W  = wme_pkg::SAMPLE_W + CNT_W;
   localparam int DIV_W  = CNT_W + wme_pkg::QUOT_W - 1;

   logic [wme_pkg::SAMPLE_W-1:0] store [WINDOW];

   logic [wme_pkg::SAMPLE_W-1:0]   sample_ff, old_ff;
   logic [SLOT_W-1:0]              slot_ff;
   logic [CNT_W-1:0]               fill_ff;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [wme_pkg::SAMPLE_W-1:0]   min_ff, max_ff;
   logic [SUM_W-1:0]               rem_ff;
   logic [DIV_W-1:0]               div_ff;
   logic [wme_pkg::QUOT_W-1:0]     quot_ff;
   logic [wme_pkg::STEP_W-1:0]     step_ff;
   logic [wme_pkg::RSP_DATA_W-1:0] res_ff;
   logic                           rsp_valid_ff;

   logic                           full;
   logic [wme_pkg::SAMPLE_W-1:0]   old_used;
   logic                           ge;
   logic [CNT_W+wme_pkg::FILLED_W-1:0] fill_wide;

   // store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         store[slot_ff] <= sample_ff;
      end
      if (cmd.take) begin
         old_ff <= store[slot_ff];
      end
   end

   assign full     = (fill_ff == CNT_W'(WINDOW));
   assign old_used = full ? old_ff : '0;
   assign sum_in   = sum_ff - SUM_W'(old_used) + SUM_W'(sample_ff);
   assign ge       = (rem_ff >= SUM_W'(div_ff));
   assign fill_wide = {{wme_pkg::FILLED_W{1'b0}}, fill_ff};

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_tdata[wme_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         min_ff  <= '1;
         max_ff  <= '0;
      end else if (cmd.update) begin
         sum_ff  <= sum_in;
         slot_ff <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (!full) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (sample_ff < min_ff) begin
            min_ff <= sample_ff;
         end
         if (sample_ff > max_ff) begin
            max_ff <= sample_ff;
         end
      end
   end

   // restoring divider, one quotient bit per cycle; mean always fits 16 bits
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff  <= sum_ff;
         div_ff  <= {fill_ff, {(wme_pkg::QUOT_W-1){1'b0}}};
         quot_ff <= '0;
         step_ff <= wme_pkg::STEP_W'(wme_pkg::QUOT_W - 1);
      end else if (cmd.step) begin
         if (ge) begin
            rem_ff <= rem_ff - SUM_W'(div_ff);
         end
         quot_ff <= {quot_ff[wme_pkg::QUOT_W-2:0], ge};
         div_ff  <= div_ff >> 1;
         step_ff <= step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_ff <= {1'b0, fill_wide[wme_pkg::FILLED_W-1:0], max_ff, min_ff, quot_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.div_last = (step_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = res_ff;

endmodule

[design/windowed_mean_with_extremes_top.sv]
// Top level of the windowed mean with extremes block.
//
//   channel  dir  word contents (lowest bit up)
//   req_     in   tdata: sample[15:0]
//   rsp_     out  tdata: mean[15:0] lowest[31:16] highest[47:32] filled[54:48], pad[55]
//
// One word in, one word out. Each word runs through accept, store/sum update,
// divider load, 16 divider steps (one quotient bit each) and result load; the
// result load waits while the output register still holds an untaken result.
// A new word is taken once the result is in the output register, so the result
// may wait for rsp_tready while the next word runs.
// reset is synchronous and active high; it clears the sum, count, slot and
// highest value and sets the lowest to all ones. The ring store needs no clearing pass.
module windowed_mean_with_extremes_top #(
   parameter int WINDOW = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: sample[15:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wme_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: mean[15:0], lowest[31:16], highest[47:32], filled[54:48], zero[55]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wme_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   wme_pkg::cmd_type    cmd;
   wme_pkg::status_type status;

   // sequencing of the update and the divide
   wme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // ring store, running sum, extremes, divider and output register
   wme_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
